@@ sv/nsr_pkg.sv @@
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared types, microcode encodings and control store for the Newton
// square root block.
// ----------------------------------------------------------------------------
package nsr_pkg;

    // Step counter width and step addresses
    localparam int UPC_W = 4;

    localparam logic [UPC_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [UPC_W-1:0] ST_CHECK     = 4'd1;
    localparam logic [UPC_W-1:0] ST_DIV1_INIT = 4'd2;
    localparam logic [UPC_W-1:0] ST_DIV1_RUN  = 4'd3;
    localparam logic [UPC_W-1:0] ST_FIRST     = 4'd4;
    localparam logic [UPC_W-1:0] ST_DIV_INIT  = 4'd5;
    localparam logic [UPC_W-1:0] ST_DIV_RUN   = 4'd6;
    localparam logic [UPC_W-1:0] ST_NEXT      = 4'd7;
    localparam logic [UPC_W-1:0] ST_OUT       = 4'd8;
    localparam logic [UPC_W-1:0] ST_SPECIAL   = 4'd9;

    // Datapath operations
    localparam logic [2:0] OP_NONE        = 3'd0;
    localparam logic [2:0] OP_LOAD        = 3'd1;
    localparam logic [2:0] OP_DIV_INIT    = 3'd2;
    localparam logic [2:0] OP_DIV_STEP    = 3'd3;
    localparam logic [2:0] OP_X_FIRST     = 3'd4;
    localparam logic [2:0] OP_X_NEXT      = 3'd5;
    localparam logic [2:0] OP_OUT_ROOT    = 3'd6;
    localparam logic [2:0] OP_OUT_SPECIAL = 3'd7;

    // Jump conditions
    localparam logic [2:0] C_NEVER     = 3'd0;
    localparam logic [2:0] C_ALWAYS    = 3'd1;
    localparam logic [2:0] C_NO_START  = 3'd2;
    localparam logic [2:0] C_SPECIAL   = 3'd3;
    localparam logic [2:0] C_DIV_BUSY  = 3'd4;
    localparam logic [2:0] C_DECREASED = 3'd5;

    // One control word per step
    typedef struct packed {
        logic [2:0]       op;
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
    } ctrl_word_t;

    // Divider control
    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // Control store
    function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_word_t cw;
        cw = '{op: OP_NONE, cond: C_ALWAYS, target: ST_IDLE};
        unique case (addr)
            ST_IDLE:      cw = '{op: OP_LOAD,        cond: C_NO_START,  target: ST_IDLE};
            ST_CHECK:     cw = '{op: OP_NONE,        cond: C_SPECIAL,   target: ST_SPECIAL};
            ST_DIV1_INIT: cw = '{op: OP_DIV_INIT,    cond: C_NEVER,     target: ST_IDLE};
            ST_DIV1_RUN:  cw = '{op: OP_DIV_STEP,    cond: C_DIV_BUSY,  target: ST_DIV1_RUN};
            ST_FIRST:     cw = '{op: OP_X_FIRST,     cond: C_NEVER,     target: ST_IDLE};
            ST_DIV_INIT:  cw = '{op: OP_DIV_INIT,    cond: C_NEVER,     target: ST_IDLE};
            ST_DIV_RUN:   cw = '{op: OP_DIV_STEP,    cond: C_DIV_BUSY,  target: ST_DIV_RUN};
            ST_NEXT:      cw = '{op: OP_X_NEXT,      cond: C_DECREASED, target: ST_DIV_INIT};
            ST_OUT:       cw = '{op: OP_OUT_ROOT,    cond: C_ALWAYS,    target: ST_IDLE};
            ST_SPECIAL:   cw = '{op: OP_OUT_SPECIAL, cond: C_ALWAYS,    target: ST_IDLE};
            default:      cw = '{op: OP_NONE,        cond: C_ALWAYS,    target: ST_IDLE};
        endcase
        return cw;
    endfunction

endpackage

@@ sv/newton_square_root_top.sv @@
// ----------------------------------------------------------------------------
// newton_square_root_top
// Floored fixed-point square root of a signed integer by Heron's iteration.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The result appears
// on root and negative_error for one cycle with done high; it cannot be held
// off, so capture it on that cycle. Negative and zero radicands go from the
// check step straight to the special output step. Otherwise the time is set
// by the serial divider, one quotient bit a cycle over W = 32 + 2*FRAC_BITS
// bits, and by the number of Newton steps after the first; the default
// FRAC_BITS of 16 gives a Q16.16 result.
// ----------------------------------------------------------------------------
module newton_square_root_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] radicand,
    output logic        done,
    output logic [31:0] root,
    output logic        negative_error
);
    import nsr_pkg::*;

    localparam int D_W = 32 + 2 * FRAC_BITS;
    localparam logic [D_W-1:0] X_ONE = D_W'(1) << FRAC_BITS;
    localparam logic [D_W-1:0] X_MIN = D_W'(1);

    logic [UPC_W-1:0] upc_reg, upc_next;
    ctrl_word_t       cw;
    logic             jump;

    logic [D_W-1:0]   n_reg, n_next;
    logic [D_W-1:0]   x_reg, x_next;
    logic             neg_reg, neg_next;
    logic             zero_reg, zero_next;
    logic [31:0]      root_reg, root_next;
    logic             err_reg, err_next;
    logic             done_reg, done_next;

    div_ctrl_t        div_ctrl;
    logic [D_W-1:0]   quo;
    logic             div_last;
    logic [D_W:0]     sum;
    logic [D_W-1:0]   x_new;
    logic             decreased;

    // Divider
    nsr_divider #(
        .W (D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (n_reg),
        .divisor  (x_reg),
        .quotient (quo),
        .last     (div_last)
    );

    // Microcode fetch and Newton update
    always_comb
    begin
        cw        = ucode_rom(upc_reg);
        sum       = {1'b0, x_reg} + {1'b0, quo};
        x_new     = sum[D_W:1];
        decreased = (x_new < x_reg);
    end

    // Jump condition and step counter
    always_comb
    begin
        case (cw.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_START:  jump = !start;
            C_SPECIAL:   jump = neg_reg | zero_reg;
            C_DIV_BUSY:  jump = !div_last;
            C_DECREASED: jump = decreased;
            default:     jump = 1'b0;
        endcase
        upc_next = jump ? cw.target : upc_reg + 1'b1;
    end

    // Datapath operation decode
    always_comb
    begin
        n_next        = n_reg;
        x_next        = x_reg;
        neg_next      = neg_reg;
        zero_next     = zero_reg;
        root_next     = root_reg;
        err_next      = err_reg;
        done_next     = 1'b0;
        div_ctrl.load = 1'b0;
        div_ctrl.step = 1'b0;
        unique case (cw.op)
            OP_NONE: ;
            OP_LOAD:
            begin
                if (start)
                begin
                    n_next    = D_W'(radicand[30:0]) << (2 * FRAC_BITS);
                    x_next    = X_ONE;
                    neg_next  = radicand[31];
                    zero_next = (radicand == 32'd0);
                end
            end
            OP_DIV_INIT: div_ctrl.load = 1'b1;
            OP_DIV_STEP: div_ctrl.step = 1'b1;
            OP_X_FIRST:  x_next = (x_new == '0) ? X_MIN : x_new;
            OP_X_NEXT:
            begin
                if (decreased)
                    x_next = x_new;
            end
            OP_OUT_ROOT:
            begin
                root_next = x_reg[31:0];
                err_next  = 1'b0;
                done_next = 1'b1;
            end
            OP_OUT_SPECIAL:
            begin
                root_next = 32'd0;
                err_next  = neg_reg;
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        x_reg    <= x_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        root_reg <= root_next;
        err_reg  <= err_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            upc_reg  <= upc_next;
            done_reg <= done_next;
        end
    end

    assign busy           = (upc_reg != ST_IDLE);
    assign done           = done_reg;
    assign root           = root_reg;
    assign negative_error = err_reg;

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside end of a request");

    a_err_root: assert property (@(posedge clk) disable iff (!rst_n)
        done && negative_error |-> root == 32'd0)
        else $error("negative radicand with non-zero root");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.load |-> x_reg != '0)
        else $error("division started with zero divisor");

endmodule

@@ sv/nsr_divider.sv @@
// ----------------------------------------------------------------------------
// nsr_divider
// Restoring unsigned divider, one quotient bit per step, stepped by the
// sequencer.
// ----------------------------------------------------------------------------
module nsr_divider #(
    parameter int W = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nsr_pkg::div_ctrl_t  ctrl,
    input  logic [W-1:0]        dividend,
    input  logic [W-1:0]        divisor,
    output logic [W-1:0]        quotient,
    output logic                last
);
    import nsr_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial    = {rem_reg, quo_reg[W-1]};
        diff     = trial - {1'b0, divisor};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CNT_W'(W);
        end
        else if (ctrl.step)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Remainder and quotient are payload
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == CNT_W'(1));

endmodule

@@ dv/newton_square_root_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// newton_square_root_top_test
// Self-checking bench for the Heron square root block. A queue of radicands,
// first a directed set and then random values, feeds a clocked driver on the
// start/busy handshake. A clocked monitor captures each done strobe and
// compares root and negative_error with an in-bench prediction.
// ----------------------------------------------------------------------------
module newton_square_root_top_test;

    localparam int FRAC_BITS     = 16;
    localparam int RANDOM_ITEMS  = 850;
    localparam int IDLE_PERCENT  = 24;
    localparam int QUIET_FIRST   = 300;
    localparam int QUIET_LAST    = 500;
    localparam int SETTLE_CYCLES = 20;

    // One queued request: radicand plus an optional drain-before-send mark
    typedef struct {
        logic [31:0] radicand;
        logic        drain;
    } request_t;

    // One predicted result
    typedef struct {
        logic [31:0] root;
        logic        negative_error;
    } root_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] radicand = 32'd0;
    logic        busy;
    logic        done;
    logic [31:0] root;
    logic        negative_error;

    logic        req_taken = 1'b0;
    int          sent_count = 0;
    int          error_count = 0;

    request_t     radicand_queue[$];
    root_result_t expected_roots[$];

    newton_square_root_top #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .radicand(radicand),
        .done(done),
        .root(root),
        .negative_error(negative_error)
    );

    // Clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Floored Heron root of v << 2*FRAC_BITS, starting from 1.0
    function automatic logic [31:0] heron_floor_root(input logic [31:0] v);
        logic [63:0] n;
        logic [63:0] x;
        logic [63:0] nxt;
        n = {32'd0, v} << (2 * FRAC_BITS);
        x = 64'd1 << FRAC_BITS;
        // first step always taken
        x = (x + n / x) >> 1;
        if (x == 64'd0)
            x = 64'd1;
        nxt = (x + n / x) >> 1;
        while (nxt < x)
        begin
            x = nxt;
            nxt = (x + n / x) >> 1;
        end
        return x[31:0];
    endfunction

    // Expected result for one radicand
    function automatic root_result_t predict_root(input logic [31:0] v);
        root_result_t r;
        r.root = 32'd0;
        r.negative_error = 1'b0;
        if (v[31])
            r.negative_error = 1'b1;
        else if (v != 32'd0)
            r.root = heron_floor_root(v);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_radicand(input logic [31:0] v, input logic drain);
        request_t req;
        req.radicand = v;
        req.drain = drain;
        radicand_queue.push_back(req);
    endtask

    // Random radicand drawn from a mix of ranges
    function automatic logic [31:0] random_radicand();
        logic [31:0] v;
        logic [31:0] r;
        int          len;
        case ($urandom_range(9))
            0, 1, 2, 3:
                v = $urandom();
            4, 5:
                v = $urandom_range(255, 1);
            6:
            begin
                len = $urandom_range(31, 1);
                v = $urandom() & ((32'd1 << len) - 32'd1);
            end
            7:
            begin
                // perfect squares and their neighbours
                r = $urandom_range(46340);
                v = r * r + 32'($urandom_range(2)) - 32'd1;
            end
            8:
                v = 32'd0;
            default:
                v = $urandom() | 32'h8000_0000;
        endcase
        return v;
    endfunction

    // Driver: offer the next request at the falling edge
    always @(negedge clk)
    begin
        request_t next_req;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || req_taken)
        begin
            if (radicand_queue.size() == 0)
                start <= 1'b0;
            else if (radicand_queue[0].drain && expected_roots.size() != 0)
                start <= 1'b0;
            else if ((sent_count < QUIET_FIRST || sent_count > QUIET_LAST)
                     && $urandom_range(99) < IDLE_PERCENT)
                start <= 1'b0;
            else
            begin
                next_req = radicand_queue.pop_front();
                start <= 1'b1;
                radicand <= next_req.radicand;
                sent_count <= sent_count + 1;
            end
        end
    end

    // Monitor: check results, then record the request taken at this edge
    always @(posedge clk)
    begin
        root_result_t exp_r;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            if (done)
            begin
                if (expected_roots.size() == 0)
                    report_mismatch($sformatf("unexpected result root=%h err=%b",
                                              root, negative_error));
                else
                begin
                    exp_r = expected_roots.pop_front();
                    if (root !== exp_r.root)
                        report_mismatch($sformatf("root %h, expected %h",
                                                  root, exp_r.root));
                    if (negative_error !== exp_r.negative_error)
                        report_mismatch($sformatf("negative_error %b, expected %b",
                                                  negative_error,
                                                  exp_r.negative_error));
                end
            end
            if (start && !busy)
                expected_roots.push_back(predict_root(radicand));
            req_taken <= start && !busy;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int i;
        // directed: field extremes, zero, negatives, squares, boundaries
        queue_radicand(32'd0, 1'b0);
        queue_radicand(32'd1, 1'b0);
        queue_radicand(32'd2, 1'b0);
        queue_radicand(32'd3, 1'b0);
        queue_radicand(32'd4, 1'b0);
        queue_radicand(32'hFFFF_FFFF, 1'b0);
        queue_radicand(32'h8000_0000, 1'b0);
        queue_radicand(32'h7FFF_FFFF, 1'b0);
        queue_radicand(32'h7FFF_FFFE, 1'b0);
        queue_radicand(32'd65535, 1'b0);
        queue_radicand(32'd65536, 1'b0);
        queue_radicand(32'h4000_0000, 1'b0);
        queue_radicand(32'd2147395600, 1'b0);
        queue_radicand(32'd2147395599, 1'b0);
        queue_radicand(32'd2147395601, 1'b0);
        queue_radicand(32'd1000000, 1'b0);
        queue_radicand(32'h5555_5555, 1'b0);
        queue_radicand(32'h2AAA_AAAA, 1'b0);
        queue_radicand(32'h8000_0001, 1'b0);
        queue_radicand(32'd0, 1'b1);
        // random part, with two drain points on the way
        for (i = 0; i < RANDOM_ITEMS; i++)
            queue_radicand(random_radicand(), (i == 100 || i == 620));

        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // wait for every request to be taken and every result to return
        while (radicand_queue.size() != 0 || (start && !req_taken)
               || expected_roots.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        #1;

        if (error_count == 0 && expected_roots.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(80_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
